@@ src/nhi_pkg.sv @@
// Shared types, codes and saturation helper for the Newton/Hermite interpolator.
// No dependencies.
`default_nettype none
package nhi_pkg;

  localparam int unsigned QW = 32;

  // kind codes (tuser of the input request)
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_EVAL  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_ZDIV = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_DEGREE = 2'd0;
  localparam logic [1:0] REG_MODE   = 2'd1;

  typedef enum logic [20:0] {
    S_IDLE    = 21'd1,
    S_LD_RD   = 21'd1 << 1,
    S_LD_CMP  = 21'd1 << 2,
    S_SH_RD   = 21'd1 << 3,
    S_SH_WR   = 21'd1 << 4,
    S_LD_WR   = 21'd1 << 5,
    S_EV_RD   = 21'd1 << 6,
    S_EV_CMP  = 21'd1 << 7,
    S_CP_RD   = 21'd1 << 8,
    S_CP_WR   = 21'd1 << 9,
    S_DW_INIT = 21'd1 << 10,
    S_DA      = 21'd1 << 11,
    S_DB      = 21'd1 << 12,
    S_DIV     = 21'd1 << 13,
    S_DSAT    = 21'd1 << 14,
    S_DNXT    = 21'd1 << 15,
    S_TERM    = 21'd1 << 16,
    S_MUL     = 21'd1 << 17,
    S_SCALE   = 21'd1 << 18,
    S_ACC     = 21'd1 << 19,
    S_DONE    = 21'd1 << 20
  } state_e;

  // clamp a wide signed value into Q16.16
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end
    if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

@@ src/newton_hermite_interpolator_top.sv @@
// Newton / Hermite divided-difference interpolator over a sorted point table.
// Depends on nhi_pkg.
//
//  channel   dir   handshake                  payload
//  s_axis    in    s_axis_tvalid/tready       tuser kind; tdata x, y, slope
//  m_axis    out   m_axis_tvalid/tready       tdata result_value, status
//  cfg       in    cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// Work per request: clear is a short path; load is an ordered scan plus a
// shift, one memory port per step; evaluate scans for the window, copies
// the nodes into the difference row, forms each divided difference (the
// 49-step radix-2 divider dominates) and then the Newton products.
// Reset clears the point count, the mode register and the output valid, and
// sets the degree register to 3; table contents stay undefined and need no clearing pass.
// The result sits in an output register; a new request is taken once the
// sequencer is back in idle, even while a result waits downstream.
`default_nettype none
module newton_hermite_interpolator_top #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned MAX_DEGREE  = 15
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,   // x_value, y_value, slope_value
  input  wire logic [1:0]   s_axis_tuser,   // kind
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [39:0]       m_axis_tdata,   // result_value, status, zero pad
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [3:0]   cfg_data_i
);
  import nhi_pkg::*;

  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LD  = MAX_DEGREE + 1;
  localparam int unsigned LW  = $clog2(LD);
  localparam int unsigned WD  = 2 * LD;
  localparam int unsigned DAW = $clog2(WD);
  localparam int unsigned TW  = $clog2(WD + 1);

  // point table and working stores
  logic [31:0] px_mem [TABLE_DEPTH];
  logic [31:0] py_mem [TABLE_DEPTH];
  logic [31:0] ps_mem [TABLE_DEPTH];
  logic [31:0] dw_mem [WD];
  logic [31:0] wx_arr [LD];
  logic [31:0] wy_arr [LD];
  logic [31:0] ws_arr [LD];
  logic [31:0] coef_arr [LD];

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          mv_q, mv_d;
  logic [3:0]    cfg_degree_q;
  logic          cfg_mode_q;

  logic signed [31:0] xin_q, yin_q, sin_q;
  logic [CW-1:0] p_q, k_q, first_q;
  logic [TW-1:0] t_q, i_q, j_q;
  logic signed [31:0] rx_q, ry_q, rs_q, dw_rd_q;
  logic signed [31:0] cur_q, nxt_q, xa_q, wv_q, d0_q, acc_q, term_q, res_q;
  logic [1:0]    stat_q;
  logic [32:0]   dv_rem_q, dv_den_q;
  logic [48:0]   dv_num_q;
  logic [5:0]    dv_cnt_q;
  logic          dv_neg_q;
  logic signed [63:0] prod_q;
  logic [39:0]   m_data_q;

  logic [TW-1:0] dd, num, nn;
  logic          accept, too_few, full, out_free;
  logic [CW-1:0] first_f, first_nf;
  logic [AW-1:0] pt_ra;
  logic [LW-1:0] nd_t, nd_ti, nd_j;
  logic signed [31:0] xb;
  logic signed [32:0] den33, diff33, qdiff33;
  logic [32:0]   den_mag, diff_mag;
  logic [33:0]   r2;
  logic          ge;
  logic signed [31:0] dv_sat, factor, scaled, accsum;
  logic signed [64:0] adj;
  logic          last_t;
  logic signed [31:0] cnext;

  function automatic logic [LW-1:0] node_of(input logic [TW-1:0] t, input logic hm);
    return hm ? LW'(t >> 1) : LW'(t);
  endfunction

  // effective degree and window sizes
  always_comb begin
    if (cfg_degree_q == 4'd0) begin
      dd = TW'(1);
    end else if (32'(cfg_degree_q) > MAX_DEGREE) begin
      dd = TW'(MAX_DEGREE);
    end else begin
      dd = TW'(cfg_degree_q);
    end
    num = dd + TW'(1);
    nn  = cfg_mode_q ? TW'(num << 1) : num;
  end

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign too_few       = 32'(cnt_q) < 32'(num);
  assign full          = 32'(cnt_q) >= TABLE_DEPTH;
  assign out_free      = !mv_q || m_axis_tready;
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = m_data_q;

  // window start: centered on the first point at or above the query, else the last points
  always_comb begin
    int unsigned half, endv;
    half = (32'(num) + 1) >> 1;
    endv = 32'(p_q) + half;
    if (endv > 32'(cnt_q)) begin
      endv = 32'(cnt_q);
    end
    first_f  = (endv >= 32'(num)) ? CW'(endv - 32'(num)) : '0;
    first_nf = CW'(32'(cnt_q) - 32'(num));
  end

  // point table read address
  always_comb begin
    case (state_q)
      S_SH_RD: pt_ra = AW'(k_q - CW'(1));
      S_CP_RD: pt_ra = AW'(first_q + CW'(j_q));
      default: pt_ra = AW'(p_q);
    endcase
  end

  // shared arithmetic
  assign nd_t    = node_of(t_q, cfg_mode_q);
  assign nd_ti   = node_of(t_q + i_q, cfg_mode_q);
  assign nd_j    = node_of(j_q, cfg_mode_q);
  assign xb      = wx_arr[nd_ti];
  assign den33   = 33'(xb) - 33'(xa_q);
  assign diff33  = 33'(dw_rd_q) - 33'(cur_q);
  assign den_mag = den33[32] ? 33'(-den33) : 33'(den33);
  assign diff_mag = diff33[32] ? 33'(-diff33) : 33'(diff33);
  assign r2      = {dv_rem_q, dv_num_q[48]};
  assign ge      = r2 >= {1'b0, dv_den_q};

  always_comb begin
    if (dv_neg_q) begin
      dv_sat = (dv_num_q > 49'h80000000) ? 32'sh80000000 : 32'(~dv_num_q + 49'd1);
    end else begin
      dv_sat = (dv_num_q > 49'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(dv_num_q);
    end
  end

  // node abscissas are signed
  assign qdiff33 = 33'(xin_q) - 33'($signed(wx_arr[nd_j]));
  assign factor  = sat32(66'(qdiff33));
  assign adj     = 65'(prod_q) + (prod_q[63] ? 65'sd65535 : 65'sd0);
  assign scaled  = sat32(66'(adj >>> 16));
  assign accsum  = sat32(66'(acc_q) + 66'(term_q));
  assign last_t  = !(32'(t_q) + 32'(i_q) + 1 < 32'(nn));
  assign cnext   = (t_q == '0) ? wv_q : d0_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mv_d    = mv_q && !m_axis_tready;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            KIND_LOAD:  state_d = S_LD_RD;
            KIND_EVAL:  state_d = too_few ? S_DONE : S_EV_RD;
            KIND_CLEAR: begin
              cnt_d   = '0;
              state_d = S_DONE;
            end
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_LD_RD: begin
        if (full) begin
          state_d = S_DONE;
        end else if (p_q == cnt_q) begin
          state_d = S_SH_RD;
        end else begin
          state_d = S_LD_CMP;
        end
      end
      S_LD_CMP: state_d = (rx_q > xin_q) ? S_SH_RD : S_LD_RD;
      S_SH_RD:  state_d = (k_q == p_q) ? S_LD_WR : S_SH_WR;
      S_SH_WR:  state_d = S_SH_RD;
      S_LD_WR: begin
        cnt_d   = cnt_q + CW'(1);
        state_d = S_DONE;
      end
      S_EV_RD:  state_d = (p_q == cnt_q) ? S_CP_RD : S_EV_CMP;
      S_EV_CMP: state_d = (rx_q >= xin_q) ? S_CP_RD : S_EV_RD;
      S_CP_RD:  state_d = S_CP_WR;
      S_CP_WR:  state_d = (j_q + TW'(1) == num) ? S_DW_INIT : S_CP_RD;
      S_DW_INIT: state_d = (t_q + TW'(1) == nn) ? S_DA : S_DW_INIT;
      S_DA:     state_d = S_DB;
      S_DB: begin
        if (den33 == '0) begin
          state_d = (i_q == TW'(1) && cfg_mode_q) ? S_DNXT : S_DONE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV:    state_d = (dv_cnt_q == 6'd48) ? S_DSAT : S_DIV;
      S_DSAT:   state_d = S_DNXT;
      S_DNXT: begin
        if (!last_t) begin
          state_d = S_DA;
        end else begin
          state_d = (i_q == dd) ? S_TERM : S_DA;
        end
      end
      S_TERM:   state_d = S_MUL;
      S_MUL:    state_d = S_SCALE;
      S_SCALE:  state_d = (j_q + TW'(1) == i_q) ? S_ACC : S_MUL;
      S_ACC:    state_d = (i_q == dd) ? S_DONE : S_TERM;
      S_DONE: begin
        if (out_free) begin
          mv_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      mv_q         <= 1'b0;
      cfg_degree_q <= 4'd3;
      cfg_mode_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mv_q    <= mv_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_DEGREE: cfg_degree_q <= cfg_data_i;
          REG_MODE:   cfg_mode_q   <= cfg_data_i[0];
          default:    ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        xin_q  <= s_axis_tdata[31:0];
        yin_q  <= s_axis_tdata[63:32];
        sin_q  <= s_axis_tdata[95:64];
        p_q    <= '0;
        k_q    <= cnt_q;
        res_q  <= '0;
        stat_q <= (s_axis_tuser == KIND_EVAL && too_few) ? ST_FEW : ST_OK;
      end
      S_LD_RD: begin
        if (full) begin
          stat_q <= ST_FULL;
        end
      end
      S_LD_CMP: begin
        if (!(rx_q > xin_q)) begin
          p_q <= p_q + CW'(1);
        end
      end
      S_SH_WR: k_q <= k_q - CW'(1);
      S_EV_RD: begin
        if (p_q == cnt_q) begin
          first_q <= first_nf;
          j_q     <= '0;
        end
      end
      S_EV_CMP: begin
        if (rx_q >= xin_q) begin
          first_q <= first_f;
          j_q     <= '0;
        end else begin
          p_q <= p_q + CW'(1);
        end
      end
      S_CP_WR: begin
        j_q <= j_q + TW'(1);
        t_q <= '0;
      end
      S_DW_INIT: begin
        if (t_q + TW'(1) == nn) begin
          t_q   <= '0;
          i_q   <= TW'(1);
          cur_q <= wy_arr[0];
          acc_q <= wy_arr[0];
        end else begin
          t_q <= t_q + TW'(1);
        end
      end
      S_DA: xa_q <= wx_arr[nd_t];
      S_DB: begin
        nxt_q <= dw_rd_q;
        if (den33 == '0) begin
          wv_q   <= ws_arr[nd_t];
          stat_q <= (i_q == TW'(1) && cfg_mode_q) ? ST_OK : ST_ZDIV;
        end else begin
          dv_rem_q <= '0;
          dv_num_q <= {diff_mag, 16'd0};
          dv_den_q <= den_mag;
          dv_neg_q <= diff33[32] ^ den33[32];
          dv_cnt_q <= '0;
        end
      end
      S_DIV: begin
        dv_rem_q <= ge ? 33'(r2 - {1'b0, dv_den_q}) : r2[32:0];
        dv_num_q <= {dv_num_q[47:0], ge};
        dv_cnt_q <= dv_cnt_q + 6'd1;
      end
      S_DSAT: wv_q <= dv_sat;
      S_DNXT: begin
        if (t_q == '0) begin
          d0_q <= wv_q;
        end
        if (!last_t) begin
          t_q   <= t_q + TW'(1);
          cur_q <= nxt_q;
        end else begin
          t_q   <= '0;
          cur_q <= cnext;
          i_q   <= (i_q == dd) ? TW'(1) : i_q + TW'(1);
        end
      end
      S_TERM: begin
        term_q <= coef_arr[LW'(i_q)];
        j_q    <= '0;
      end
      S_MUL: prod_q <= 64'(term_q) * 64'(factor);
      S_SCALE: begin
        term_q <= scaled;
        j_q    <= j_q + TW'(1);
      end
      S_ACC: begin
        acc_q <= accsum;
        if (i_q == dd) begin
          res_q <= accsum;
        end else begin
          i_q <= i_q + TW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          m_data_q <= {6'd0, stat_q, res_q};
        end
      end
      default: ;
    endcase
  end

  // memories and working arrays
  always_ff @(posedge clk_i) begin
    rx_q    <= px_mem[pt_ra];
    ry_q    <= py_mem[pt_ra];
    rs_q    <= ps_mem[pt_ra];
    dw_rd_q <= dw_mem[DAW'(t_q + TW'(1))];
    case (state_q)
      S_SH_WR: begin
        px_mem[AW'(k_q)] <= rx_q;
        py_mem[AW'(k_q)] <= ry_q;
        ps_mem[AW'(k_q)] <= rs_q;
      end
      S_LD_WR: begin
        px_mem[AW'(p_q)] <= xin_q;
        py_mem[AW'(p_q)] <= yin_q;
        ps_mem[AW'(p_q)] <= sin_q;
      end
      S_CP_WR: begin
        wx_arr[LW'(j_q)] <= rx_q;
        wy_arr[LW'(j_q)] <= ry_q;
        ws_arr[LW'(j_q)] <= rs_q;
      end
      S_DW_INIT: dw_mem[DAW'(t_q)] <= wy_arr[nd_t];
      S_DNXT: begin
        dw_mem[DAW'(t_q)] <= wv_q;
        if (last_t) begin
          coef_arr[LW'(i_q)] <= cnext;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
